// ===== src/udpck_pkg.sv =====
// udpck_pkg: shared types, constants and the one's-complement fold for the
// UDP pseudo-header checksum core. No dependencies.
`default_nettype none

package udpck_pkg;

  // Default depth of the queue between the front and back parts
  localparam int QUEUE_DEPTH = 4;

  // Byte count codes of an input transaction
  localparam logic [1:0] BC_EMPTY = 2'd0;
  localparam logic [1:0] BC_ONE   = 2'd1;
  localparam logic [1:0] BC_TWO   = 2'd2;
  localparam logic [1:0] BC_THREE = 2'd3;

  localparam logic [15:0] WORD_ONES   = 16'hFFFF;
  localparam logic [16:0] PAYLOAD_MAX = 17'h1FFFF;
  localparam logic [17:0] UDP_HDR_LEN = 18'd8;

  typedef struct packed {
    logic        first_item;
    logic        last_item;
    logic [15:0] data_word;
    logic [1:0]  byte_count;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } in_item_t;

  typedef struct packed {
    logic [15:0] checksum;
    logic [15:0] udp_length;
    logic        length_overflow;
    logic        odd_byte_misplaced;
  } out_item_t;

  // Classified transaction as it travels through the queue
  typedef struct packed {
    logic        first;
    logic        last;
    logic        udp;
    logic        misplaced;
    logic [1:0]  cnt;
    logic [15:0] addend;
  } q_entry_t;

  // Finished datagram waiting for the final complement
  typedef struct packed {
    logic        udp;
    logic        flag;
    logic        ovf;
    logic [15:0] len16;
    logic [15:0] sum;
  } fin_t;

  // End-around carry fold of a sum of up to eight 16-bit words
  function automatic logic [15:0] oc_fold(input logic [18:0] s);
    logic [16:0] f1;
    f1 = {1'b0, s[15:0]} + {14'b0, s[18:16]};
    return f1[15:0] + {15'b0, f1[16]};
  endfunction

endpackage

`default_nettype wire

// ===== src/udp_pseudo_header_checksum_core.sv =====
// udp_pseudo_header_checksum_core: top level of the UDP pseudo-header
// checksum engine. Uses udpck_pkg, udpck_front, udpck_queue, udpck_back.
//
// Usage:
//   in_valid/in_stall carry one 16-bit payload word per transaction, first
//   byte in the upper half, with first_item/last_item framing marks. On a
//   first item in UDP mode the addresses, protocol and ports are folded in.
//   out_valid/out_stall carry one result per last item: checksum, the UDP
//   length, a length overflow flag and a flag for a lone byte mid-datagram.
//   cfg_wr_en/cfg_wr_data write udp_mode (reset 1); write it only while idle.
// Throughput: one transaction per cycle while the queue is not full. The
//   front folds each transaction to one addend in its accept cycle; the
//   back adds one addend a cycle unless a last item waits for the finish
//   stage to be free. A last item passes through the queue, the finish
//   stage and the output register, in that order.
// Reset: clears the running sum, byte count, flag, queue and output valid;
//   udp_mode returns to UDP.
// Stall: with out_stall high the result holds in the output register while
//   the finish stage and the queue keep filling; in_stall rises only once
//   the queue is full.
`default_nettype none

module udp_pseudo_header_checksum_core #(
  parameter int QUEUE_DEPTH = udpck_pkg::QUEUE_DEPTH
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_wr_en,
  input  wire                   cfg_wr_data,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  udpck_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  wire                   out_stall,
  output udpck_pkg::out_item_t  out_item
);
  import udpck_pkg::*;

  q_entry_t q_wr_data;
  q_entry_t q_rd_data;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  // Front: accept and classify each transaction
  udpck_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wr_data   (q_wr_data)
  );

  // Queue: decouple the accept side from the accumulate side
  udpck_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back: accumulate, finish and hold the result for the receiver
  udpck_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_rd_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== src/udpck_front.sv =====
// udpck_front: holds the mode register, accepts input transactions and
// reduces each one to a single one's-complement addend. Uses udpck_pkg.
`default_nettype none

module udpck_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_wr_en,
  input  wire                  cfg_wr_data,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  udpck_pkg::in_item_t  in_item,
  input  wire                  q_full,
  output logic                 q_push,
  output udpck_pkg::q_entry_t  q_wr_data
);
  import udpck_pkg::*;

  logic        udp_mode;
  logic        pseudo_en;
  logic [1:0]  cnt_eff;
  logic [15:0] word_term;
  logic [18:0] raw_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      udp_mode <= 1'b1;
    end else if (cfg_wr_en) begin
      udp_mode <= cfg_wr_data;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign pseudo_en = in_item.first_item && udp_mode;

  // Treat a count of three as two
  always_comb begin
    if (in_item.byte_count inside {BC_TWO, BC_THREE}) begin
      cnt_eff = BC_TWO;
    end else begin
      cnt_eff = in_item.byte_count;
    end
  end

  always_comb begin
    case (cnt_eff)
      BC_TWO:  word_term = in_item.data_word;
      BC_ONE:  word_term = {in_item.data_word[15:8], 8'h00};
      default: word_term = 16'h0000;
    endcase
  end

  // Pseudo header and port words join the payload word on a first item
  always_comb begin
    raw_sum = {3'b0, word_term};
    if (pseudo_en) begin
      raw_sum = raw_sum
              + {3'b0, in_item.src_addr[31:16]} + {3'b0, in_item.src_addr[15:0]}
              + {3'b0, in_item.dst_addr[31:16]} + {3'b0, in_item.dst_addr[15:0]}
              + {11'b0, in_item.protocol}
              + {3'b0, in_item.src_port} + {3'b0, in_item.dst_port};
    end
  end

  always_comb begin
    q_wr_data.first     = in_item.first_item;
    q_wr_data.last      = in_item.last_item;
    q_wr_data.udp       = udp_mode;
    q_wr_data.misplaced = (cnt_eff == BC_ONE) && !in_item.last_item;
    q_wr_data.cnt       = cnt_eff;
    q_wr_data.addend    = oc_fold(raw_sum);
  end

endmodule

`default_nettype wire

// ===== src/udpck_queue.sv =====
// udpck_queue: short register queue of classified transactions between the
// front and back parts. Uses udpck_pkg.
`default_nettype none

module udpck_queue #(
  parameter int DEPTH = udpck_pkg::QUEUE_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  udpck_pkg::q_entry_t  wr_data,
  input  wire                  pop,
  output udpck_pkg::q_entry_t  rd_data,
  output logic                 full,
  output logic                 empty
);
  import udpck_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           entries [DEPTH];
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [CNT_W-1:0]   count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== src/udpck_back.sv =====
// udpck_back: drains the queue into the running sum and byte count, then
// finishes each datagram into the output register. Uses udpck_pkg.
`default_nettype none

module udpck_back (
  input  wire                  clk,
  input  wire                  rst,
  input  udpck_pkg::q_entry_t  head,
  input  wire                  q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output udpck_pkg::out_item_t out_item
);
  import udpck_pkg::*;

  logic [15:0] running_sum;
  logic [16:0] payload_bytes;
  logic        misplaced_flag;

  logic [15:0] running_next;
  logic [16:0] payload_next;
  logic        flag_next;
  logic [16:0] payload_base;
  logic [17:0] payload_sum;
  logic [17:0] total;
  logic        total_ovf;

  fin_t        fin;
  fin_t        fin_next;
  logic        fin_valid;
  logic        fin_adv;
  logic        fin_free;
  logic        out_ready;

  logic [17:0] final_sum;
  logic [15:0] final_fold;
  logic [15:0] ck_udp;
  out_item_t   out_next;

  assign out_ready = !out_valid || !out_stall;
  assign fin_adv   = fin_valid && out_ready;
  assign fin_free  = !fin_valid || fin_adv;
  assign q_pop     = !q_empty && (!head.last || fin_free);

  // Accumulate: a first item restarts the state
  always_comb begin
    running_next = head.first ? head.addend
                 : oc_fold({3'b0, running_sum} + {3'b0, head.addend});
    payload_base = head.first ? 17'h0 : payload_bytes;
    payload_sum  = {1'b0, payload_base} + {16'b0, head.cnt};
    payload_next = payload_sum[17] ? PAYLOAD_MAX : payload_sum[16:0];
    flag_next    = (head.first ? 1'b0 : misplaced_flag) | head.misplaced;
    total        = {1'b0, payload_next} + UDP_HDR_LEN;
    total_ovf    = total[17] || total[16];

    fin_next.udp  = head.udp;
    fin_next.flag = flag_next;
    fin_next.sum  = running_next;
    if (head.udp) begin
      fin_next.ovf   = total_ovf;
      fin_next.len16 = total_ovf ? WORD_ONES : total[15:0];
    end else begin
      fin_next.ovf   = 1'b0;
      fin_next.len16 = 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= 16'h0000;
      payload_bytes  <= 17'h0;
      misplaced_flag <= 1'b0;
    end else if (q_pop) begin
      running_sum    <= running_next;
      payload_bytes  <= payload_next;
      misplaced_flag <= flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (q_pop && head.last) begin
      fin_valid <= 1'b1;
    end else if (fin_adv) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && head.last) begin
      fin <= fin_next;
    end
  end

  // Finish: length word enters twice, so add it shifted left by one
  always_comb begin
    final_sum  = {2'b0, fin.sum} + {1'b0, fin.len16, 1'b0};
    final_fold = oc_fold({1'b0, final_sum});
    ck_udp     = ~final_fold;
    if (ck_udp == 16'h0000) begin
      ck_udp = WORD_ONES;
    end
    out_next.checksum           = fin.udp ? ck_udp : ~fin.sum;
    out_next.udp_length         = fin.len16;
    out_next.length_overflow    = fin.ovf;
    out_next.odd_byte_misplaced = fin.flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_adv) begin
      out_item <= out_next;
    end
  end

  a_ovf_saturates: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.length_overflow) |-> (out_item.udp_length == WORD_ONES))
    else $error("overflow flagged without saturated length");

  a_udp_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.udp_length != 16'h0000)) |-> (out_item.checksum != 16'h0000))
    else $error("UDP checksum of zero sent");

endmodule

`default_nettype wire
